// ===== src/msq_pkg.sv =====
// Shared types and constants of the I2C master message sequencer.
// No dependencies; all design files except msq_if refer to it by scoped names.
package msq_pkg;

  localparam int DEFAULT_LEN_WIDTH   = 16;
  localparam int DEFAULT_QUEUE_DEPTH = 2;
  localparam int MSG_LEN_BITS        = 16;
  localparam int BYTE_INDEX_BITS     = 16;

  // Codes of the operation field.
  localparam logic OP_START = 1'b0;
  localparam logic OP_EVENT = 1'b1;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_SEND  = 3'd2,
    ACT_STORE = 3'd3,
    ACT_STOP  = 3'd4,
    ACT_NEXT  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NODEV = 2'd1,
    ST_ARB   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_WRITE = 2'd2,
    PH_READ  = 2'd3
  } phase_t;

  // Class of a queued item, decided in the front end.
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_ABORT = 2'd1,
    KIND_EVENT = 2'd2
  } kind_t;

  // What the back end does with the item at the head of the queue.
  typedef enum logic [3:0] {
    OC_LOAD       = 4'd0,
    OC_ABORT      = 4'd1,
    OC_IDLE_STOP  = 4'd2,
    OC_NODEV      = 4'd3,
    OC_END        = 4'd4,
    OC_READ_BEGIN = 4'd5,
    OC_SEND       = 4'd6,
    OC_STORE      = 4'd7,
    OC_END_BYTE   = 4'd8
  } outcome_t;

  typedef struct packed {
    kind_t                   kind;
    logic [7:0]              addr_byte;
    logic                    read;
    logic [MSG_LEN_BITS-1:0] length;
    logic                    last;
    logic                    nak;
    logic [7:0]              rx;
    logic [7:0]              tx;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t data;
  } q_push_t;

  typedef struct packed {
    logic   valid;
    entry_t data;
  } q_head_t;

  typedef struct packed {
    action_t                    action;
    logic [7:0]                 out_byte;
    logic [BYTE_INDEX_BITS-1:0] byte_index;
    logic                       ack_next;
    logic                       done_res;
    status_t                    status;
  } res_t;

endpackage

// ===== src/msq_if.sv =====
// Valid/ready channel interfaces of the message sequencer: items in, results out.
// Depends on nothing; field widths follow the block's item and result formats.
interface msq_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [6:0]  target_addr;
  logic        read_flag;
  logic [15:0] msg_length;
  logic        last_message;
  logic        arb_lost;
  logic        no_ack;
  logic [7:0]  rx_byte;
  logic [7:0]  tx_byte;

  modport source (
    output valid, operation, target_addr, read_flag, msg_length, last_message,
           arb_lost, no_ack, rx_byte, tx_byte,
    input  ready
  );
  modport sink (
    input  valid, operation, target_addr, read_flag, msg_length, last_message,
           arb_lost, no_ack, rx_byte, tx_byte,
    output ready
  );
endinterface

interface msq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  out_byte;
  logic [15:0] byte_index;
  logic        ack_next;
  logic        done_res;
  logic [1:0]  status;

  modport source (
    output valid, action, out_byte, byte_index, ack_next, done_res, status,
    input  ready
  );
  modport sink (
    input  valid, action, out_byte, byte_index, ack_next, done_res, status,
    output ready
  );
endinterface

// ===== src/msq_front.sv =====
// Front end: takes item transfers and classifies them into queue entries.
// Depends on msq_pkg and msq_in_if.
module msq_front (
  msq_in_if.sink          cmd,
  input  logic            q_full,
  output msq_pkg::q_push_t q_wr
);

  always_comb begin
    cmd.ready           = !q_full;
    q_wr.push           = cmd.valid && !q_full;
    q_wr.data.addr_byte = {cmd.target_addr, cmd.read_flag};
    q_wr.data.read      = cmd.read_flag;
    q_wr.data.length    = cmd.msg_length;
    q_wr.data.last      = cmd.last_message;
    q_wr.data.nak       = cmd.no_ack;
    q_wr.data.rx        = cmd.rx_byte;
    q_wr.data.tx        = cmd.tx_byte;
    // Arbitration loss ends the transfer whatever the phase, so it is
    // sorted out here and the back end need not look at it again.
    if (cmd.operation == msq_pkg::OP_START) begin
      q_wr.data.kind = msq_pkg::KIND_START;
    end else if (cmd.arb_lost) begin
      q_wr.data.kind = msq_pkg::KIND_ABORT;
    end else begin
      q_wr.data.kind = msq_pkg::KIND_EVENT;
    end
  end

endmodule

// ===== src/msq_queue.sv =====
// Short first-in first-out queue of classified entries between front and back end.
// Depends on msq_pkg; storage is a small register array.
module msq_queue #(
  parameter int DEPTH = msq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  msq_pkg::q_push_t wr,
  input  logic             pop,
  output logic             full,
  output msq_pkg::q_head_t rd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  msq_pkg::entry_t  slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd.valid = (count != '0);
  assign rd.data  = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr.push) begin
      slots[wptr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr.push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !wr.push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_up: assert property (@(posedge clk) disable iff (rst)
    wr.push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not rise on a lone push");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && !wr.push |=> count == $past(count) - 1'b1)
    else $error("queue count did not fall on a lone pop");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from an empty queue");
`endif

endmodule

// ===== src/msq_back.sv =====
// Back end: carries out queued entries against the transfer state, one per cycle
// unless stalled, into a result register. Depends on msq_pkg and msq_out_if.
module msq_back #(
  parameter int LEN_WIDTH = msq_pkg::DEFAULT_LEN_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  msq_pkg::q_head_t head,
  output logic             pop,
  msq_out_if.source        res
);

  msq_pkg::phase_t        phase;
  msq_pkg::phase_t        phase_next;
  logic [LEN_WIDTH-1:0]   byte_count;
  logic [LEN_WIDTH-1:0]   byte_count_next;
  logic [LEN_WIDTH-1:0]   cur_len;
  logic [LEN_WIDTH-1:0]   cur_len_next;
  logic                   reading;
  logic                   reading_next;
  logic                   final_msg;
  logic                   final_msg_next;

  logic                   out_valid;
  msq_pkg::res_t          res_q;
  msq_pkg::res_t          res_next;
  msq_pkg::outcome_t      outcome;
  msq_pkg::entry_t        e;

  logic [LEN_WIDTH-1:0]   cnt_inc;
  logic                   have_more;
  logic                   last_rd;
  logic                   ack_rd;

  assign e         = head.data;
  assign pop       = head.valid && (!out_valid || res.ready);
  assign cnt_inc   = byte_count + 1'b1;
  assign have_more = byte_count < cur_len;
  assign last_rd   = (cnt_inc == cur_len);
  assign ack_rd    = ((cur_len - cnt_inc) != LEN_WIDTH'(1));

  // Decide what the head entry does.
  always_comb begin
    case (e.kind)
      msq_pkg::KIND_START: outcome = msq_pkg::OC_LOAD;
      msq_pkg::KIND_ABORT: outcome = msq_pkg::OC_ABORT;
      default: begin
        case (phase)
          msq_pkg::PH_START: begin
            if (e.nak) begin
              outcome = msq_pkg::OC_NODEV;
            end else if (!have_more) begin
              outcome = msq_pkg::OC_END;
            end else if (reading) begin
              outcome = msq_pkg::OC_READ_BEGIN;
            end else begin
              outcome = msq_pkg::OC_SEND;
            end
          end
          msq_pkg::PH_WRITE: begin
            if (e.nak) begin
              outcome = msq_pkg::OC_NODEV;
            end else if (have_more) begin
              outcome = msq_pkg::OC_SEND;
            end else begin
              outcome = msq_pkg::OC_END;
            end
          end
          msq_pkg::PH_READ: begin
            if (!have_more) begin
              outcome = msq_pkg::OC_END;
            end else if (last_rd) begin
              outcome = msq_pkg::OC_END_BYTE;
            end else begin
              outcome = msq_pkg::OC_STORE;
            end
          end
          default: outcome = msq_pkg::OC_IDLE_STOP;
        endcase
      end
    endcase
  end

  // Next state.
  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    cur_len_next    = cur_len;
    reading_next    = reading;
    final_msg_next  = final_msg;
    case (outcome)
      msq_pkg::OC_LOAD: begin
        phase_next      = msq_pkg::PH_START;
        byte_count_next = '0;
        cur_len_next    = e.length[LEN_WIDTH-1:0];
        reading_next    = e.read;
        final_msg_next  = e.last;
      end
      msq_pkg::OC_READ_BEGIN: phase_next = msq_pkg::PH_READ;
      msq_pkg::OC_SEND: begin
        phase_next      = msq_pkg::PH_WRITE;
        byte_count_next = cnt_inc;
      end
      msq_pkg::OC_STORE: byte_count_next = cnt_inc;
      default: begin
        phase_next      = msq_pkg::PH_IDLE;
        byte_count_next = '0;
      end
    endcase
  end

  // Result fields.
  always_comb begin
    res_next            = '0;
    res_next.action     = msq_pkg::ACT_NONE;
    res_next.status     = msq_pkg::ST_OK;
    case (outcome)
      msq_pkg::OC_LOAD: begin
        res_next.action   = msq_pkg::ACT_START;
        res_next.out_byte = e.addr_byte;
      end
      msq_pkg::OC_ABORT: begin
        res_next.action   = msq_pkg::ACT_STOP;
        res_next.done_res = 1'b1;
        res_next.status   = msq_pkg::ST_ARB;
      end
      msq_pkg::OC_NODEV: begin
        res_next.action   = msq_pkg::ACT_STOP;
        res_next.done_res = 1'b1;
        res_next.status   = msq_pkg::ST_NODEV;
      end
      msq_pkg::OC_END: begin
        res_next.action   = final_msg ? msq_pkg::ACT_STOP : msq_pkg::ACT_NEXT;
        res_next.done_res = final_msg;
      end
      msq_pkg::OC_READ_BEGIN: begin
        res_next.ack_next = (cur_len > LEN_WIDTH'(1));
      end
      msq_pkg::OC_SEND: begin
        res_next.action     = msq_pkg::ACT_SEND;
        res_next.out_byte   = e.tx;
        res_next.byte_index = msq_pkg::BYTE_INDEX_BITS'(byte_count);
      end
      msq_pkg::OC_STORE: begin
        res_next.action     = msq_pkg::ACT_STORE;
        res_next.out_byte   = e.rx;
        res_next.byte_index = msq_pkg::BYTE_INDEX_BITS'(byte_count);
        res_next.ack_next   = ack_rd;
      end
      msq_pkg::OC_END_BYTE: begin
        res_next.action     = final_msg ? msq_pkg::ACT_STOP : msq_pkg::ACT_NEXT;
        res_next.done_res   = final_msg;
        res_next.out_byte   = e.rx;
        res_next.byte_index = msq_pkg::BYTE_INDEX_BITS'(byte_count);
      end
      default: begin
        res_next.action   = msq_pkg::ACT_STOP;
        res_next.done_res = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= msq_pkg::PH_IDLE;
      byte_count <= '0;
      cur_len    <= '0;
      reading    <= 1'b0;
      final_msg  <= 1'b0;
    end else if (pop) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      cur_len    <= cur_len_next;
      reading    <= reading_next;
      final_msg  <= final_msg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_q <= res_next;
    end
  end

  assign res.valid      = out_valid;
  assign res.action     = res_q.action;
  assign res.out_byte   = res_q.out_byte;
  assign res.byte_index = res_q.byte_index;
  assign res.ack_next   = res_q.ack_next;
  assign res.done_res   = res_q.done_res;
  assign res.status     = res_q.status;

`ifndef SYNTHESIS
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == msq_pkg::PH_READ |-> byte_count < cur_len)
    else $error("read phase with byte count at or past the length");
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    phase == msq_pkg::PH_IDLE |-> byte_count == '0)
    else $error("idle phase with a nonzero byte count");
  a_end_goes_idle: assert property (@(posedge clk) disable iff (rst)
    pop && (res_next.action == msq_pkg::ACT_STOP || res_next.action == msq_pkg::ACT_NEXT)
    |=> phase == msq_pkg::PH_IDLE)
    else $error("stop or next-message result without return to idle");
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    pop && e.kind == msq_pkg::KIND_START |=> phase == msq_pkg::PH_START && byte_count == '0)
    else $error("start item did not load a fresh message");
`endif

endmodule

// ===== src/i2c_master_message_sequencer.sv =====
// Top level of the I2C master message sequencer: front end, entry queue and back end.
// Depends on msq_pkg, msq_if, msq_front, msq_queue and msq_back.
//
// The block turns start-message items and bus interrupt events into one action each:
// a start with the address byte, a byte to send, a received byte to store with the
// acknowledge choice for the following byte, a request for the next message, or a
// stop with a status (ok, no device acknowledge, arbitration lost). Every accepted
// item gives exactly one result, in order. The front end classifies each item and
// places it in a short queue; the back end takes one entry per clock unless a result
// waits unaccepted, updates the phase and byte counter, and writes the result into
// an output register. The sustained rate is one item per clock while results are
// accepted; each item waits in a queue slot before its result is registered. While
// results wait unaccepted, the queue absorbs up to QUEUE_DEPTH items before ready
// drops. Message lengths use the low LEN_WIDTH bits of msg_length. A start item
// abandons any transfer in progress; an idle event stops with ok unless arb_lost.
module i2c_master_message_sequencer #(
  parameter int LEN_WIDTH   = msq_pkg::DEFAULT_LEN_WIDTH,
  parameter int QUEUE_DEPTH = msq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  msq_in_if.sink    cmd,
  msq_out_if.source res
);

  msq_pkg::q_push_t q_wr;
  msq_pkg::q_head_t q_rd;
  logic             q_full;
  logic             q_pop;

  // Classification of each item transfer into a queue entry.
  msq_front u_front (
    .cmd    (cmd),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  // Decouples acceptance from execution so each side stalls on its own.
  msq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_wr),
    .pop  (q_pop),
    .full (q_full),
    .rd   (q_rd)
  );

  // Transfer state and result register.
  msq_back #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .head (q_rd),
    .pop  (q_pop),
    .res  (res)
  );

endmodule

// ===== tb/sv/i2c_master_message_sequencer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the I2C master message sequencer: directed and random transfers.
// Depends on msq_pkg, msq_if and i2c_master_message_sequencer from src.
module i2c_master_message_sequencer_tb;
  import msq_pkg::*;

  // One input transfer as the testbench sees it.
  typedef struct packed {
    logic        operation;
    logic [6:0]  target_addr;
    logic        read_flag;
    logic [15:0] msg_length;
    logic        last_message;
    logic        arb_lost;
    logic        no_ack;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } bus_item_t;

  // Tracks the sequencer state on its own and keeps the actions still owed by the block.
  // Every accepted item owes exactly one action, so the queue is strictly in order.
  class action_scoreboard;
    phase_t      phase;
    logic [15:0] byte_count;
    logic [15:0] cur_len;
    logic        reading;
    logic        final_msg;
    res_t        pending_actions[$];
    int          errors;

    function new();
      phase      = PH_IDLE;
      byte_count = '0;
      cur_len    = '0;
      reading    = 1'b0;
      final_msg  = 1'b0;
      errors     = 0;
    endfunction

    function int pending();
      return pending_actions.size();
    endfunction

    // Ending a transfer or a message always returns the sequencer to idle.
    function res_t stop_with(status_t st, logic [7:0] b, logic [15:0] idx);
      res_t r;
      r = '0;
      phase = PH_IDLE;
      byte_count = '0;
      r.action = ACT_STOP;
      r.out_byte = b;
      r.byte_index = idx;
      r.done_res = 1'b1;
      r.status = st;
      return r;
    endfunction

    // End of a message: stop after the final one, otherwise ask for the next.
    function res_t end_message(logic [7:0] b, logic [15:0] idx);
      res_t r;
      r = '0;
      if (final_msg) begin
        return stop_with(ST_OK, b, idx);
      end
      phase = PH_IDLE;
      byte_count = '0;
      r.action = ACT_NEXT;
      r.out_byte = b;
      r.byte_index = idx;
      return r;
    endfunction

    function res_t predict_action(bus_item_t it);
      res_t        r;
      logic [15:0] idx;
      r = '0;
      if (it.operation == OP_START) begin
        // A new message always wins, whatever was in progress.
        reading    = it.read_flag;
        cur_len    = it.msg_length;
        final_msg  = it.last_message;
        byte_count = '0;
        phase      = PH_START;
        r.action   = ACT_START;
        r.out_byte = {it.target_addr, it.read_flag};
        return r;
      end
      if (it.arb_lost) begin
        return stop_with(ST_ARB, 8'h00, 16'h0000);
      end
      if (phase == PH_START) begin
        if (it.no_ack) begin
          return stop_with(ST_NODEV, 8'h00, 16'h0000);
        end
        if (byte_count >= cur_len) begin
          return end_message(8'h00, 16'h0000);
        end
        if (reading) begin
          phase = PH_READ;
          r.ack_next = (cur_len > 16'd1);
          return r;
        end
        // A write sends its first byte on the address acknowledge itself.
        phase = PH_WRITE;
      end
      if (phase == PH_WRITE) begin
        if (it.no_ack) begin
          return stop_with(ST_NODEV, 8'h00, 16'h0000);
        end
        if (byte_count < cur_len) begin
          r.action = ACT_SEND;
          r.out_byte = it.tx_byte;
          r.byte_index = byte_count;
          byte_count = byte_count + 16'd1;
          return r;
        end
        return end_message(8'h00, 16'h0000);
      end
      if (phase == PH_READ) begin
        // The master gives the acknowledges on a read, so no_ack plays no part here.
        if (byte_count >= cur_len) begin
          return end_message(8'h00, 16'h0000);
        end
        idx = byte_count;
        byte_count = byte_count + 16'd1;
        if (byte_count < cur_len) begin
          r.action = ACT_STORE;
          r.out_byte = it.rx_byte;
          r.byte_index = idx;
          r.ack_next = (cur_len - byte_count != 16'd1);
          return r;
        end
        return end_message(it.rx_byte, idx);
      end
      // A bus event with no transfer under way.
      return stop_with(ST_OK, 8'h00, 16'h0000);
    endfunction

    function void note_item(bus_item_t it);
      pending_actions.push_back(predict_action(it));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_actions.size() == 0) begin
        $error("unexpected result: action %0d out_byte %0h", got.action, got.out_byte);
        errors++;
        return;
      end
      want = pending_actions.pop_front();
      if (got.action !== want.action) begin
        $error("action: expected %0d, got %0d", want.action, got.action);
        errors++;
      end
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.byte_index !== want.byte_index) begin
        $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
        errors++;
      end
      if (got.ack_next !== want.ack_next) begin
        $error("ack_next: expected %0b, got %0b", want.ack_next, got.ack_next);
        errors++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic steady;       // While set, neither side inserts gaps or stalls.
  int   items_sent;

  msq_in_if  cmd_ch();
  msq_out_if res_ch();

  action_scoreboard sb;

  i2c_master_message_sequencer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Reset is asserted only at the very start and never again.
  initial begin
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Hard limit: the slowest legal run stays far below this.
  initial begin
    #2_000_000;
    $display("i2c_master_message_sequencer_tb failed");
    $finish;
  end

  // Result side: ready is low with a chance of about 28 in a hundred, except in the steady stretch.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= steady || ($urandom_range(99) >= 28);
    end
  end

  // Every result transfer is checked against the oldest outstanding prediction. Sampling
  // in the active region of the edge sees the values that the block held before the edge.
  always @(posedge clk) begin
    res_t got;
    if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got.action     = action_t'(res_ch.action);
      got.out_byte   = res_ch.out_byte;
      got.byte_index = res_ch.byte_index;
      got.ack_next   = res_ch.ack_next;
      got.done_res   = res_ch.done_res;
      got.status     = status_t'(res_ch.status);
      sb.check_result(got);
    end
  end

  function automatic bus_item_t msg_start(logic [6:0] addr, logic rd, logic [15:0] len,
                                          logic last);
    bus_item_t it;
    // Fields that a start ignores still carry random values.
    it = bus_item_t'({$urandom, $urandom});
    it.operation    = OP_START;
    it.target_addr  = addr;
    it.read_flag    = rd;
    it.msg_length   = len;
    it.last_message = last;
    return it;
  endfunction

  function automatic bus_item_t bus_event(logic arb, logic nak, logic [7:0] rx, logic [7:0] tx);
    bus_item_t it;
    it = bus_item_t'({$urandom, $urandom});
    it.operation = OP_EVENT;
    it.arb_lost  = arb;
    it.no_ack    = nak;
    it.rx_byte   = rx;
    it.tx_byte   = tx;
    return it;
  endfunction

  // Drives one item, with random gaps before it, and holds it until the block takes it.
  // Called at a clock edge and returns at the edge of the transfer, so valid gets one
  // assignment per edge and stays high between back-to-back items.
  task automatic send_item(bus_item_t it);
    while (!steady && $urandom_range(99) < 28) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.operation    <= it.operation;
    cmd_ch.target_addr  <= it.target_addr;
    cmd_ch.read_flag    <= it.read_flag;
    cmd_ch.msg_length   <= it.msg_length;
    cmd_ch.last_message <= it.last_message;
    cmd_ch.arb_lost     <= it.arb_lost;
    cmd_ch.no_ack       <= it.no_ack;
    cmd_ch.rx_byte      <= it.rx_byte;
    cmd_ch.tx_byte      <= it.tx_byte;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  // Short directed run through the corners of the sequencing.
  task automatic run_directed();
    // Bus events with no transfer: plain stop, and arbitration loss while idle.
    send_item(bus_event(1'b0, 1'b0, 8'hff, 8'h00));
    send_item(bus_event(1'b1, 1'b0, 8'h00, 8'hff));
    // Final write of length zero stops right after the address.
    send_item(msg_start(7'h7f, 1'b0, 16'd0, 1'b1));
    send_item(bus_event(1'b0, 1'b0, 8'h00, 8'h00));
    // Read of length zero that is not final asks for the next message.
    send_item(msg_start(7'h00, 1'b1, 16'd0, 1'b0));
    send_item(bus_event(1'b0, 1'b0, 8'h00, 8'h00));
    // Read of one byte: no acknowledge for that byte, and the stop carries it.
    send_item(msg_start(7'h55, 1'b1, 16'd1, 1'b1));
    send_item(bus_event(1'b0, 1'b0, 8'h00, 8'h00));
    send_item(bus_event(1'b0, 1'b0, 8'hff, 8'h00));
    // Two-byte write that is not final.
    send_item(msg_start(7'h2a, 1'b0, 16'd2, 1'b0));
    send_item(bus_event(1'b0, 1'b0, 8'h00, 8'hff));
    send_item(bus_event(1'b0, 1'b0, 8'hff, 8'h00));
    send_item(bus_event(1'b0, 1'b0, 8'h00, 8'h00));
    // No device answers the address.
    send_item(msg_start(7'h11, 1'b0, 16'd3, 1'b1));
    send_item(bus_event(1'b0, 1'b1, 8'h00, 8'h00));
    // Slave refuses a written byte.
    send_item(msg_start(7'h12, 1'b0, 16'd2, 1'b1));
    send_item(bus_event(1'b0, 1'b0, 8'h00, 8'ha5));
    send_item(bus_event(1'b0, 1'b1, 8'h00, 8'h5a));
    // Three-byte read with a stray no_ack, which a read ignores.
    send_item(msg_start(7'h33, 1'b1, 16'd3, 1'b1));
    send_item(bus_event(1'b0, 1'b0, 8'h00, 8'h00));
    send_item(bus_event(1'b0, 1'b1, 8'h81, 8'h00));
    send_item(bus_event(1'b0, 1'b0, 8'h7e, 8'h00));
    send_item(bus_event(1'b0, 1'b0, 8'hc3, 8'h00));
    // Longest message, abandoned by a new start, then lost arbitration mid-write.
    send_item(msg_start(7'h7f, 1'b1, 16'hffff, 1'b1));
    send_item(bus_event(1'b0, 1'b0, 8'h00, 8'h00));
    send_item(msg_start(7'h01, 1'b0, 16'hffff, 1'b0));
    send_item(bus_event(1'b0, 1'b0, 8'h00, 8'h3c));
    send_item(bus_event(1'b1, 1'b0, 8'h00, 8'h00));
  endtask

  // Random run: mostly whole messages with random contents, broken now and then by
  // arbitration loss, a refused byte or an early new start, plus fully random noise.
  task automatic run_random(int count);
    int          first;
    int          pick;
    int          n_ev;
    int          k;
    logic [15:0] len;
    first = items_sent;
    while (items_sent - first < count) begin
      steady <= (items_sent - first >= 300 && items_sent - first < 450);
      pick = $urandom_range(99);
      if (pick < 85) begin
        pick = $urandom_range(99);
        if (pick < 90) begin
          len = 16'($urandom_range(0, 6));
        end else if (pick < 95) begin
          len = 16'hffff;
        end else begin
          len = 16'($urandom);
        end
        // Long messages are cut short; the next start abandons them.
        n_ev = (len > 16'd6) ? $urandom_range(1, 8) : int'(len) + 1;
        if ($urandom_range(9) == 0) n_ev++;
        send_item(msg_start(7'($urandom), 1'($urandom), len, 1'($urandom)));
        for (k = 0; k < n_ev; k++) begin
          pick = $urandom_range(99);
          send_item(bus_event(pick < 3, pick >= 3 && pick < 6, 8'($urandom), 8'($urandom)));
        end
      end else begin
        send_item(bus_item_t'({$urandom, $urandom}));
      end
    end
    steady <= 1'b0;
  endtask

  // Main sequence: directed part, random part, drain, verdict.
  initial begin
    sb = new();
    steady <= 1'b0;
    items_sent = 0;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.operation    <= OP_EVENT;
    cmd_ch.target_addr  <= '0;
    cmd_ch.read_flag    <= 1'b0;
    cmd_ch.msg_length   <= '0;
    cmd_ch.last_message <= 1'b0;
    cmd_ch.arb_lost     <= 1'b0;
    cmd_ch.no_ack       <= 1'b0;
    cmd_ch.rx_byte      <= '0;
    cmd_ch.tx_byte      <= '0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    run_directed();
    run_random(800);
    cmd_ch.valid <= 1'b0;
    // Drain the outstanding actions, then give the block time to show any extra result.
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("i2c_master_message_sequencer_tb passed");
    end else begin
      $display("i2c_master_message_sequencer_tb failed");
    end
    $finish;
  end

endmodule
